FILE: sv/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OPERAND_WIDTH = 16;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]                      cmd;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [OPERAND_WIDTH-1:0] res_num;
        logic signed [OPERAND_WIDTH-1:0] res_den;
        logic                            div_zero;
        logic                            overflow;
    } out_item_t;

endpackage

FILE: sv/rau_divider.sv
`timescale 1ns / 1ps

// Restoring signed divider, one quotient bit per cycle, truncating.
// A zero divisor yields quotient 0 and remainder 0.
module rau_divider #(
    parameter int W = 2 * rau_pkg::OPERAND_WIDTH + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] dividend,
    input  logic signed [W-1:0] divisor,
    output logic                done,
    output logic signed [W-1:0] quotient,
    output logic signed [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic          qneg_reg, qneg_next;
    logic          rneg_reg, rneg_next;
    logic          zero_reg, zero_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        zero_next = zero_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg, quo_reg[W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        // load magnitudes
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[W-1] ? W'(-dividend) : W'(dividend);
            dsr_next  = divisor[W-1] ? W'(-divisor) : W'(divisor);
            qneg_next = dividend[W-1] ^ divisor[W-1];
            rneg_next = dividend[W-1];
            zero_next = (divisor == '0);
            busy_next = 1'b1;
            cnt_next  = CW'(W);
        end
        // advance one bit
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
        zero_reg <= zero_next;
    end

    assign done      = done_reg;
    assign quotient  = zero_reg ? '0 : (qneg_reg ? $signed(-quo_reg) : $signed(quo_reg));
    assign remainder = zero_reg ? '0 : (rneg_reg ? $signed(-rem_reg) : $signed(rem_reg));

endmodule

FILE: sv/rational_arithmetic_unit_core.sv
`timescale 1ns / 1ps

// Rational arithmetic unit: one reduced fraction per command.
// Input channel (in_valid/in_ready, in_data) carries cmd and two fractions;
// output channel (out_valid/out_ready, out_data) carries the reduced fraction
// with div_zero and overflow flags. Commands: add, subtract, multiply, divide.
// One item at a time: in_ready is high only when the sequencer is idle and
// the output register is empty. All quotients and remainders come from one
// shared bit-serial divider of 2*OPERAND_WIDTH+1 bits; each division is a
// start step, one step per quotient bit, then a step for the done flag.
// Latency is data dependent and set by the number of divisions: each Euclid
// step is one division, up to about 24 steps for the first gcd on 16-bit
// operands and about 46 for the final reduction of the 32-bit products, plus
// two to five quotient divisions. Multiplies use one shared multiplier, one
// product per cycle. Divide with a zero second numerator presents its result
// in the cycle after the transfer. Reset clears the sequencer and drops any
// held result. When the receiver stalls, the result is held in the output
// register and no new item is taken.
module rational_arithmetic_unit_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rau_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rau_pkg::out_item_t out_data
);

    localparam int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH;
    localparam int W  = 2 * OPERAND_WIDTH + 1;
    localparam int SW = 4;

    localparam logic [SW-1:0] S_IDLE     = 4'd0;
    localparam logic [SW-1:0] S_GCD_ST   = 4'd1;
    localparam logic [SW-1:0] S_GCD_WT   = 4'd2;
    localparam logic [SW-1:0] S_Q1_ST    = 4'd3;
    localparam logic [SW-1:0] S_Q1_WT    = 4'd4;
    localparam logic [SW-1:0] S_Q2_ST    = 4'd5;
    localparam logic [SW-1:0] S_Q2_WT    = 4'd6;
    localparam logic [SW-1:0] S_Q3_ST    = 4'd7;
    localparam logic [SW-1:0] S_Q3_WT    = 4'd8;
    localparam logic [SW-1:0] S_MUL1     = 4'd9;
    localparam logic [SW-1:0] S_MUL2     = 4'd10;
    localparam logic [SW-1:0] S_OUT      = 4'd11;

    // phase of the operation
    localparam logic [1:0] P_PRE   = 2'd0;  // first gcd (add/sub/div)
    localparam logic [1:0] P_FINAL = 2'd1;  // final reduction

    logic [SW-1:0] state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic signed [W-1:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [W-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic signed [W-1:0] x_reg, x_next, y_reg, y_next;   // gcd operands
    logic signed [W-1:0] g_reg, g_next;
    logic signed [W-1:0] t1_reg, t1_next, t2_reg, t2_next;
    logic signed [W-1:0] num_reg, num_next, den_reg, den_next;
    logic                ov_valid_reg, ov_valid_next;
    rau_pkg::out_item_t  res_reg, res_next;

    // shared divider
    logic                dv_start;
    logic signed [W-1:0] dv_a, dv_b, dv_q, dv_r;
    logic                dv_done;

    rau_divider #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .dividend  (dv_a),
        .divisor   (dv_b),
        .done      (dv_done),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    // shared multiplier
    logic signed [W-1:0]   mul_a, mul_b;
    logic signed [2*W-1:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [W-1:0] hi_lim, lo_lim;
    assign hi_lim = W'((64'sd1 <<< (OPERAND_WIDTH - 1)) - 1);
    assign lo_lim = -hi_lim - W'(1);

    // y equal to +/-1 gives remainder 0, as does the divider's zero case
    logic signed [W-1:0] gcd_rem;
    assign gcd_rem = (y_reg == W'(1) || y_reg == -W'(1)) ? '0 : dv_r;

    // quotient by -1 is a plain negation, matched by the divider already
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        x_next = x_reg; y_next = y_reg; g_next = g_reg;
        t1_next = t1_reg; t2_next = t2_reg;
        num_next = num_reg; den_next = den_reg;
        ov_valid_next = ov_valid_reg;
        res_next      = res_reg;
        dv_start      = 1'b0;
        dv_a          = x_reg;
        dv_b          = y_reg;
        mul_a         = an_reg;
        mul_b         = bn_reg;

        // drop result on transfer
        if (ov_valid_reg && out_ready)
            ov_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_valid_reg)
                begin
                    cmd_next = in_data.cmd;
                    an_next  = W'(in_data.a_num);
                    ad_next  = W'(in_data.a_den);
                    bn_next  = W'(in_data.b_num);
                    bd_next  = W'(in_data.b_den);
                    if (in_data.cmd == rau_pkg::CMD_DIV && in_data.b_num == '0)
                    begin
                        res_next.res_num  = in_data.a_num;
                        res_next.res_den  = in_data.a_den;
                        res_next.div_zero = 1'b1;
                        res_next.overflow = 1'b0;
                        ov_valid_next     = 1'b1;
                    end
                    else if (in_data.cmd == rau_pkg::CMD_MUL)
                        state_next = S_MUL1;
                    else
                    begin
                        phase_next = P_PRE;
                        x_next     = W'(in_data.b_den);
                        y_next     = (in_data.cmd == rau_pkg::CMD_DIV) ?
                                     W'(in_data.b_num) : W'(in_data.a_den);
                        state_next = S_GCD_ST;
                    end
                end
            end
            // Euclid loop, one remainder per division
            S_GCD_ST:
            begin
                if (y_reg == '0)
                begin
                    g_next = x_reg;
                    mul_a  = bd_reg;
                    mul_b  = ad_reg;
                    if (phase_reg == P_PRE)
                    begin
                        // add/sub: den = bd*ad / g ; div: bd / h
                        if (cmd_reg == rau_pkg::CMD_DIV)
                            t1_next = bd_reg;
                        else
                            t1_next = W'(mul_p);
                    end
                    state_next = S_Q1_ST;
                end
                else
                begin
                    dv_start   = 1'b1;
                    state_next = S_GCD_WT;
                end
            end
            S_GCD_WT:
            begin
                if (dv_done)
                begin
                    x_next     = y_reg;
                    y_next     = gcd_rem;
                    state_next = S_GCD_ST;
                end
            end
            // first quotient
            S_Q1_ST:
            begin
                dv_start = 1'b1;
                if (phase_reg == P_FINAL)
                    dv_a = num_reg;
                else
                    dv_a = t1_reg;
                dv_b       = g_reg;
                state_next = S_Q1_WT;
            end
            S_Q1_WT:
            begin
                if (dv_done)
                begin
                    t1_next    = dv_q;
                    state_next = S_Q2_ST;
                end
            end
            // second quotient
            S_Q2_ST:
            begin
                dv_start = 1'b1;
                if (phase_reg == P_FINAL)
                begin
                    dv_a = den_reg;
                    dv_b = g_reg;
                end
                else if (cmd_reg == rau_pkg::CMD_DIV)
                begin
                    dv_a = bn_reg;
                    dv_b = g_reg;
                end
                else
                begin
                    dv_a = t1_reg;   // den / ad
                    dv_b = ad_reg;
                end
                state_next = S_Q2_WT;
            end
            S_Q2_WT:
            begin
                if (dv_done)
                begin
                    t2_next = dv_q;
                    if (phase_reg == P_FINAL)
                        state_next = S_OUT;
                    else if (cmd_reg == rau_pkg::CMD_DIV)
                        state_next = S_MUL1;
                    else
                        state_next = S_Q3_ST;
                end
            end
            // add/sub third quotient: den / bd
            S_Q3_ST:
            begin
                dv_start   = 1'b1;
                dv_a       = t1_reg;
                dv_b       = bd_reg;
                state_next = S_Q3_WT;
            end
            S_Q3_WT:
            begin
                if (dv_done)
                begin
                    den_next   = t1_reg;
                    g_next     = dv_q;          // den / bd held here
                    state_next = S_MUL1;
                end
            end
            // first product
            S_MUL1:
            begin
                if (cmd_reg == rau_pkg::CMD_MUL)
                begin
                    mul_a = an_reg; mul_b = bn_reg;
                end
                else if (cmd_reg == rau_pkg::CMD_DIV)
                begin
                    mul_a = an_reg; mul_b = t1_reg;
                end
                else
                begin
                    mul_a = an_reg; mul_b = t2_reg;  // an * (den/ad)
                end
                num_next   = W'(mul_p);
                state_next = S_MUL2;
            end
            // second product, add/sub combine, then final reduction
            S_MUL2:
            begin
                if (cmd_reg == rau_pkg::CMD_MUL)
                begin
                    mul_a = ad_reg; mul_b = bd_reg;
                    den_next = W'(mul_p);
                end
                else if (cmd_reg == rau_pkg::CMD_DIV)
                begin
                    mul_a = ad_reg; mul_b = t2_reg;
                    den_next = W'(mul_p);
                end
                else
                begin
                    mul_a = bn_reg; mul_b = g_reg;   // bn * (den/bd)
                    if (cmd_reg == rau_pkg::CMD_ADD)
                        num_next = W'(mul_p) + num_reg;
                    else
                        num_next = num_reg - W'(mul_p);
                end
                phase_next = P_FINAL;
                x_next     = num_next;
                y_next     = den_next;
                state_next = S_GCD_ST;
            end
            // reduced result, overflow check
            S_OUT:
            begin
                res_next.res_num  = t1_reg[OPERAND_WIDTH-1:0];
                res_next.res_den  = t2_reg[OPERAND_WIDTH-1:0];
                res_next.div_zero = 1'b0;
                res_next.overflow = (t1_reg < lo_lim) || (t1_reg > hi_lim) ||
                                    (t2_reg < lo_lim) || (t2_reg > hi_lim);
                ov_valid_next     = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= P_PRE;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        an_reg  <= an_next;
        ad_reg  <= ad_next;
        bn_reg  <= bn_next;
        bd_reg  <= bd_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        g_reg   <= g_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        num_reg <= num_next;
        den_reg <= den_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE) && !ov_valid_reg;
    assign out_valid = ov_valid_reg;
    assign out_data  = res_reg;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    rau_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    rau_pkg::out_item_t out_data;

    rau_pkg::in_item_t  pending_ops[$];
    rau_pkg::out_item_t expected_fractions[$];
    int        idle_pct;
    int        stall_pct;
    int        errors = 0;
    logic      in_fire;

    rational_arithmetic_unit_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Quotient with zero divisor taken as zero
    function automatic longint safe_quot(longint x, longint y);
        if (y == 0)
            return 0;
        if (y == -1)
            return -x;
        return x / y;
    endfunction

    // Euclid gcd with truncating remainder; sign follows the dividend
    function automatic longint euclid_gcd(longint x, longint y);
        longint t;
        while (y != 0)
        begin
            if (y == 1 || y == -1)
                t = 0;
            else
                t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Work out the reduced fraction for one command
    function automatic rau_pkg::out_item_t reduce_fraction(rau_pkg::in_item_t it);
        rau_pkg::out_item_t r;
        longint an, ad, bn, bd, num, den, g, rn, rd, h, ta, tb;
        an = longint'(it.a_num);
        ad = longint'(it.a_den);
        bn = longint'(it.b_num);
        bd = longint'(it.b_den);
        if (it.cmd == rau_pkg::CMD_DIV && bn == 0)
        begin
            r.res_num  = it.a_num;
            r.res_den  = it.a_den;
            r.div_zero = 1'b1;
            r.overflow = 1'b0;
            return r;
        end
        if (it.cmd == rau_pkg::CMD_ADD || it.cmd == rau_pkg::CMD_SUB)
        begin
            g   = euclid_gcd(bd, ad);
            den = safe_quot(bd * ad, g);
            ta  = an * safe_quot(den, ad);
            tb  = bn * safe_quot(den, bd);
            num = (it.cmd == rau_pkg::CMD_ADD) ? tb + ta : ta - tb;
        end
        else if (it.cmd == rau_pkg::CMD_MUL)
        begin
            num = an * bn;
            den = ad * bd;
        end
        else
        begin
            h   = euclid_gcd(bd, bn);
            num = an * safe_quot(bd, h);
            den = ad * safe_quot(bn, h);
        end
        g  = euclid_gcd(num, den);
        rn = safe_quot(num, g);
        rd = safe_quot(den, g);
        r.res_num  = rn[15:0];
        r.res_den  = rd[15:0];
        r.div_zero = 1'b0;
        r.overflow = (rn < -32768 || rn > 32767 || rd < -32768 || rd > 32767);
        return r;
    endfunction

    // Operand value: half small, some full range, some extremes
    function automatic logic [15:0] pick_operand();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return 16'($signed($urandom_range(40)) - 20);
        if (sel < 8)
            return 16'($urandom);
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic rau_pkg::in_item_t make_op(logic [1:0] c, logic [15:0] an,
                                                  logic [15:0] ad, logic [15:0] bn,
                                                  logic [15:0] bd);
        rau_pkg::in_item_t it;
        it.cmd   = c;
        it.a_num = an;
        it.a_den = ad;
        it.b_num = bn;
        it.b_den = bd;
        return it;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive the input channel at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_fire)
        begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_ops.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Record input transfers and check output transfers
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_fractions.push_back(reduce_fraction(in_data));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_fractions.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                errors++;
            end
            else
            begin
                if (out_data.res_num !== expected_fractions[0].res_num ||
                    out_data.res_den !== expected_fractions[0].res_den ||
                    out_data.div_zero !== expected_fractions[0].div_zero ||
                    out_data.overflow !== expected_fractions[0].overflow)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time,
                             expected_fractions[0], out_data);
                    errors++;
                end
                void'(expected_fractions.pop_front());
            end
        end
    end

    initial
    begin
        #300_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        logic [1:0] c;
        rst_n     = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every command, zero divisor and zero denominators
        pending_ops.push_back(make_op(rau_pkg::CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd3));
        pending_ops.push_back(make_op(rau_pkg::CMD_SUB, 16'd1, 16'd2, 16'd1, 16'd3));
        pending_ops.push_back(make_op(rau_pkg::CMD_MUL, 16'd2, 16'd3, 16'd3, 16'd4));
        pending_ops.push_back(make_op(rau_pkg::CMD_DIV, 16'd2, 16'd3, 16'd3, 16'd4));
        pending_ops.push_back(make_op(rau_pkg::CMD_DIV, 16'd5, 16'd10, 16'd0, 16'd7));
        pending_ops.push_back(make_op(rau_pkg::CMD_DIV, 16'h8000, 16'h8000, 16'd0, 16'd0));
        pending_ops.push_back(make_op(rau_pkg::CMD_ADD, 16'd0, 16'd0, 16'd0, 16'd0));
        pending_ops.push_back(make_op(rau_pkg::CMD_MUL, 16'd3, 16'd0, 16'd4, 16'd5));
        pending_ops.push_back(make_op(rau_pkg::CMD_SUB, 16'd3, 16'd0, 16'd4, 16'd0));
        pending_ops.push_back(make_op(rau_pkg::CMD_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1));
        pending_ops.push_back(make_op(rau_pkg::CMD_MUL, 16'h7fff, 16'd1, 16'h7fff, 16'd1));
        pending_ops.push_back(make_op(rau_pkg::CMD_ADD, 16'h7fff, 16'd1, 16'h7fff, 16'd1));
        pending_ops.push_back(make_op(rau_pkg::CMD_SUB, 16'h8000, 16'd1, 16'h7fff, 16'd1));
        pending_ops.push_back(make_op(rau_pkg::CMD_ADD, 16'd1, 16'h7fff, 16'd1, 16'h7ffe));
        pending_ops.push_back(make_op(rau_pkg::CMD_ADD, 16'd1, -16'sd4, 16'd1, 16'd6));
        pending_ops.push_back(make_op(rau_pkg::CMD_SUB, -16'sd3, -16'sd9, 16'd2, -16'sd6));
        pending_ops.push_back(make_op(rau_pkg::CMD_DIV, 16'd7, 16'd1, -16'sd3, 16'd5));
        pending_ops.push_back(make_op(rau_pkg::CMD_DIV, 16'h8000, 16'h7fff, 16'hffff,
                                      16'h8000));
        pending_ops.push_back(make_op(rau_pkg::CMD_MUL, 16'hffff, 16'hffff, 16'hffff,
                                      16'hffff));
        pending_ops.push_back(make_op(rau_pkg::CMD_DIV, 16'd1, 16'd1, 16'h8000, 16'h7fff));

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 16 : 0;
            stall_pct = (ph == 2) ? 67 : (ph == 3) ? 16 : 0;
            for (int i = 0; i < 470; i++)
            begin
                c = 2'($urandom_range(3));
                pending_ops.push_back(make_op(c, pick_operand(), pick_operand(),
                    ($urandom_range(15) == 0) ? 16'd0 : pick_operand(), pick_operand()));
            end
            // Hold off until the block has drained
            wait (pending_ops.size() == 0 && !in_valid && expected_fractions.size() == 0);
            @(posedge clk);
        end

        repeat (100) @(posedge clk);
        if (errors == 0 && expected_fractions.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
